// ===== hw/rtl/ilx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indent lexer package
// Shared constants, result kind codes and the divider request and result
// types of the indentation-to-block-marker lexer.
// ----------------------------------------------------------------------------
package ilx_pkg;

  // Columns per indent level and the deepest level allowed.
  localparam int INDENT_WIDTH = 4;
  localparam int MAX_LEVELS   = 15;

  // Width of the column count, which saturates at its all-ones value.
  localparam int COUNT_W   = 8;
  localparam logic [COUNT_W-1:0] COUNT_CAP = '1;

  // Width of a stored indent level.
  localparam int LEVEL_W = $clog2(MAX_LEVELS + 1);

  // Width of a division remainder, which is always below INDENT_WIDTH.
  localparam int REM_W = $clog2(INDENT_WIDTH) + 1;

  // Reciprocal of the indent width, rounded up. With this shift the
  // product gives the exact quotient for every column count.
  localparam int DIV_SHIFT = COUNT_W + $clog2(INDENT_WIDTH);
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + INDENT_WIDTH - 1) / INDENT_WIDTH);
  localparam int PROD_W    = COUNT_W + RECIP_W;

  // Result kinds.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_BYTE      = 3'd0;
  localparam kind_t KIND_INDENT    = 3'd1;
  localparam kind_t KIND_DEDENT    = 3'd2;
  localparam kind_t KIND_BAD_WIDTH = 3'd3;
  localparam kind_t KIND_TOO_DEEP  = 3'd4;

  // Characters with a meaning at line start.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Request to the column divider.
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
  } div_req_t;

  // Answer of the column divider; quotient and remainder hold until the
  // next start.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] quotient;
    logic [REM_W-1:0]   remainder;
  } div_res_t;

endpackage

// ===== hw/rtl/ilx_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column divider
// Splits a column count into indent level and remainder by multiplying with
// the reciprocal of the indent width; the answer is registered on start.
// ----------------------------------------------------------------------------
module ilx_divider (
  input  logic              clk,
  input  logic              rst,
  input  ilx_pkg::div_req_t req,
  output ilx_pkg::div_res_t res
);

  logic [ilx_pkg::COUNT_W-1:0] quo;
  logic [ilx_pkg::REM_W-1:0]   rem;
  logic                        done;

  logic [ilx_pkg::PROD_W-1:0]  product;
  logic [ilx_pkg::COUNT_W-1:0] quo_calc;
  logic [ilx_pkg::COUNT_W-1:0] back;
  logic [ilx_pkg::COUNT_W-1:0] rem_full;

  // Quotient from the reciprocal product, remainder by multiplying back.
  always_comb begin
    product  = ilx_pkg::PROD_W'(req.dividend) * ilx_pkg::PROD_W'(ilx_pkg::DIV_RECIP);
    quo_calc = product[ilx_pkg::DIV_SHIFT +: ilx_pkg::COUNT_W];
    back     = quo_calc * ilx_pkg::COUNT_W'(ilx_pkg::INDENT_WIDTH);
    rem_full = req.dividend - back;
  end

  // The answer is registered on start, and done pulses for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      quo  <= '0;
      rem  <= '0;
      done <= 1'b0;
    end else begin
      done <= req.start;
      if (req.start) begin
        quo <= quo_calc;
        rem <= rem_full[ilx_pkg::REM_W-1:0];
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// ===== hw/rtl/indent_to_block_marker_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation to block marker lexer
// Turns leading indentation of source text into indent and dedent markers.
// ----------------------------------------------------------------------------
// Bytes in the body of a line, and spaces and tabs at line start, are taken
// at one item per cycle unless the result side stalls. The first other byte
// of a line is taken, the divider splits the column count into level and
// remainder, and the block decides. A blank line's newline or an indentation
// error gives a single result, after which the block takes input again; a
// saturated column count gives its error without the divider. A byte that
// opens a line body holds the input until the indent or dedent markers
// emitted ahead of it and the byte are sent. Results leave through a single
// output register, and the input is not ready while a result waits there
// unaccepted, so a stalling result side holds the input too. After an
// indentation error the block gives no results until the byte marked with
// tlast, and every tlast byte returns the block to its reset state.
// ----------------------------------------------------------------------------
module indent_to_block_marker_lexer (
  input  logic       clk,
  input  logic       rst,
  // Input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_text
  // Result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [2:0] kind
  output logic       m_axis_tlast    // run_last
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Lexer state.
  logic                        in_line_body;
  logic [ilx_pkg::COUNT_W-1:0] column_count;
  logic [ilx_pkg::LEVEL_W-1:0] previous_level;
  logic                        error_seen;
  logic                        in_line_body_next;
  logic [ilx_pkg::COUNT_W-1:0] column_count_next;
  logic [ilx_pkg::LEVEL_W-1:0] previous_level_next;
  logic                        error_seen_next;

  // Byte held while its line start is worked out.
  logic [7:0]                  hold_byte;
  logic                        hold_last;
  logic [ilx_pkg::LEVEL_W-1:0] marks;
  ilx_pkg::kind_t              mark_kind;
  logic [7:0]                  hold_byte_next;
  logic                        hold_last_next;
  logic [ilx_pkg::LEVEL_W-1:0] marks_next;
  ilx_pkg::kind_t              mark_kind_next;

  // Output register.
  logic           out_valid;
  ilx_pkg::kind_t out_kind;
  logic [7:0]     out_byte;
  logic           out_last;
  logic           out_valid_next;
  ilx_pkg::kind_t out_kind_next;
  logic [7:0]     out_byte_next;
  logic           out_last_next;

  ilx_pkg::div_req_t div_req;
  ilx_pkg::div_res_t div_res;

  logic                        out_free;
  logic                        s_fire;
  logic                        is_ws;
  logic [ilx_pkg::COUNT_W:0]   ws_sum;
  logic [ilx_pkg::COUNT_W-1:0] ws_count;
  logic [ilx_pkg::LEVEL_W-1:0] new_level;
  logic                        too_deep;

  ilx_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // Handshake and line-start decode.
  always_comb begin
    out_free      = !out_valid || m_axis_tready;
    s_axis_tready = (state == ST_IDLE) && out_free;
    s_fire        = s_axis_tvalid && s_axis_tready;
    is_ws         = (s_axis_tdata == ilx_pkg::CHAR_SPACE) ||
                    (s_axis_tdata == ilx_pkg::CHAR_TAB);
    if (s_axis_tdata == ilx_pkg::CHAR_SPACE) begin
      ws_sum = {1'b0, column_count} + (ilx_pkg::COUNT_W + 1)'(1);
    end else begin
      ws_sum = {1'b0, column_count} +
               (ilx_pkg::COUNT_W + 1)'(ilx_pkg::INDENT_WIDTH);
    end
    ws_count = ws_sum[ilx_pkg::COUNT_W] ? ilx_pkg::COUNT_CAP :
               ws_sum[ilx_pkg::COUNT_W-1:0];
    div_req.start    = s_fire && !error_seen && !in_line_body && !is_ws &&
                       (column_count != ilx_pkg::COUNT_CAP);
    div_req.dividend = column_count;
    too_deep  = div_res.quotient > ilx_pkg::COUNT_W'(ilx_pkg::MAX_LEVELS);
    new_level = div_res.quotient[ilx_pkg::LEVEL_W-1:0];
  end

  // Sequencer, lexer state and output register: next values.
  always_comb begin
    state_next          = state;
    in_line_body_next   = in_line_body;
    column_count_next   = column_count;
    previous_level_next = previous_level;
    error_seen_next     = error_seen;
    hold_byte_next      = hold_byte;
    hold_last_next      = hold_last;
    marks_next          = marks;
    mark_kind_next      = mark_kind;
    out_valid_next      = out_valid && !m_axis_tready;
    out_kind_next       = out_kind;
    out_byte_next       = out_byte;
    out_last_next       = out_last;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (error_seen) begin
            // Bytes after an error are dropped.
          end else if (in_line_body) begin
            out_valid_next = 1'b1;
            out_kind_next  = ilx_pkg::KIND_BYTE;
            out_byte_next  = s_axis_tdata;
            out_last_next  = 1'b1;
            if (s_axis_tdata == ilx_pkg::CHAR_NEWLINE) begin
              in_line_body_next = 1'b0;
              column_count_next = '0;
            end
          end else if (is_ws) begin
            column_count_next = ws_count;
          end else if (column_count == ilx_pkg::COUNT_CAP) begin
            out_valid_next  = 1'b1;
            out_kind_next   = ilx_pkg::KIND_TOO_DEEP;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            error_seen_next = 1'b1;
          end else begin
            hold_byte_next = s_axis_tdata;
            hold_last_next = s_axis_tlast;
            state_next     = ST_DIV;
          end
          // The final byte of a text returns the lexer state to reset, except
          // when the byte waits for the divider.
          if (s_axis_tlast && !div_req.start) begin
            in_line_body_next   = 1'b0;
            column_count_next   = '0;
            previous_level_next = '0;
            error_seen_next     = 1'b0;
          end
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (out_free) begin
          if (div_res.remainder != '0) begin
            out_valid_next  = 1'b1;
            out_kind_next   = ilx_pkg::KIND_BAD_WIDTH;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            error_seen_next = !hold_last;
            state_next      = ST_IDLE;
          end else if (hold_byte == ilx_pkg::CHAR_NEWLINE) begin
            // Blank line: the newline passes and the level stays.
            out_valid_next    = 1'b1;
            out_kind_next     = ilx_pkg::KIND_BYTE;
            out_byte_next     = hold_byte;
            out_last_next     = 1'b1;
            column_count_next = '0;
            state_next        = ST_IDLE;
          end else if (too_deep) begin
            out_valid_next  = 1'b1;
            out_kind_next   = ilx_pkg::KIND_TOO_DEEP;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            error_seen_next = !hold_last;
            state_next      = ST_IDLE;
          end else begin
            if (new_level > previous_level) begin
              marks_next     = new_level - previous_level;
              mark_kind_next = ilx_pkg::KIND_INDENT;
            end else begin
              marks_next     = previous_level - new_level;
              mark_kind_next = ilx_pkg::KIND_DEDENT;
            end
            previous_level_next = new_level;
            column_count_next   = '0;
            in_line_body_next   = 1'b1;
            state_next          = ST_EMIT;
          end
          if (hold_last) begin
            column_count_next   = '0;
            previous_level_next = '0;
            in_line_body_next   = 1'b0;
          end
        end
      end

      ST_EMIT: begin
        // One marker per cycle while the output register is free, then the byte that opened the line.
        if (out_free) begin
          out_valid_next = 1'b1;
          if (marks != '0) begin
            out_kind_next = mark_kind;
            out_byte_next = '0;
            out_last_next = 1'b0;
            marks_next    = marks - 1'b1;
          end else begin
            out_kind_next = ilx_pkg::KIND_BYTE;
            out_byte_next = hold_byte;
            out_last_next = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      in_line_body   <= 1'b0;
      column_count   <= '0;
      previous_level <= '0;
      error_seen     <= 1'b0;
      hold_byte      <= '0;
      hold_last      <= 1'b0;
      marks          <= '0;
      mark_kind      <= ilx_pkg::KIND_INDENT;
      out_valid      <= 1'b0;
      out_kind       <= ilx_pkg::KIND_BYTE;
      out_byte       <= '0;
      out_last       <= 1'b0;
    end else begin
      state          <= state_next;
      in_line_body   <= in_line_body_next;
      column_count   <= column_count_next;
      previous_level <= previous_level_next;
      error_seen     <= error_seen_next;
      hold_byte      <= hold_byte_next;
      hold_last      <= hold_last_next;
      marks          <= marks_next;
      mark_kind      <= mark_kind_next;
      out_valid      <= out_valid_next;
      out_kind       <= out_kind_next;
      out_byte       <= out_byte_next;
      out_last       <= out_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

// ===== verif/indent_to_block_marker_lexer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indent lexer testbench
// Sends short source texts into the lexer and predicts every indent marker,
// dedent marker, passed byte and error. A scoreboard compares each result
// with the oldest prediction. Directed texts come first and random texts
// follow. During the random texts both stream sides stall at random in bursts.
// ----------------------------------------------------------------------------
module indent_to_block_marker_lexer_tb;

  // One predicted result item.
  typedef struct {
    ilx_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } marker_t;

  // Tracks the line state of the lexer and holds the results still to come.
  class marker_scoreboard;
    logic        in_body;
    int unsigned col;
    int unsigned level;
    logic        err;
    marker_t     due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned kind_seen[5];

    function new();
      clear_state();
      mismatches = 0;
      checked    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void clear_state();
      in_body = 1'b0;
      col     = 0;
      level   = 0;
      err     = 1'b0;
    endfunction

    function marker_t mk(ilx_pkg::kind_t k, logic [7:0] d);
      marker_t m;
      m.kind = k;
      m.data = d;
      m.last = 1'b0;
      return m;
    endfunction

    // Predicts the results of one accepted byte. Returns 1 when the byte
    // was not ignored because of an earlier error.
    function bit note_input(logic [7:0] b, logic last);
      marker_t     batch[$];
      bit          active;
      int unsigned lvl;
      active = !err;
      if (active) begin
        if (in_body) begin
          batch.push_back(mk(ilx_pkg::KIND_BYTE, b));
          if (b == ilx_pkg::CHAR_NEWLINE) begin
            in_body = 1'b0;
            col     = 0;
          end
        end else if (b == ilx_pkg::CHAR_SPACE || b == ilx_pkg::CHAR_TAB) begin
          // Leading whitespace only counts columns; the count saturates.
          col = col + ((b == ilx_pkg::CHAR_SPACE) ? 1 : ilx_pkg::INDENT_WIDTH);
          if (col > ilx_pkg::COUNT_CAP) col = 32'(ilx_pkg::COUNT_CAP);
        end else if (col >= ilx_pkg::COUNT_CAP) begin
          batch.push_back(mk(ilx_pkg::KIND_TOO_DEEP, 8'h00));
          err = 1'b1;
        end else if (col % ilx_pkg::INDENT_WIDTH != 0) begin
          batch.push_back(mk(ilx_pkg::KIND_BAD_WIDTH, 8'h00));
          err = 1'b1;
        end else if (b == ilx_pkg::CHAR_NEWLINE) begin
          // A blank line keeps the current level.
          col = 0;
          batch.push_back(mk(ilx_pkg::KIND_BYTE, b));
        end else begin
          lvl = col / ilx_pkg::INDENT_WIDTH;
          if (lvl > ilx_pkg::MAX_LEVELS) begin
            batch.push_back(mk(ilx_pkg::KIND_TOO_DEEP, 8'h00));
            err = 1'b1;
          end else begin
            for (int unsigned i = level; i < lvl; i++)
              batch.push_back(mk(ilx_pkg::KIND_INDENT, 8'h00));
            for (int unsigned i = lvl; i < level; i++)
              batch.push_back(mk(ilx_pkg::KIND_DEDENT, 8'h00));
            level   = lvl;
            col     = 0;
            in_body = 1'b1;
            batch.push_back(mk(ilx_pkg::KIND_BYTE, b));
          end
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) due.push_back(batch[i]);
      if (last) clear_state();
      return active;
    endfunction

    // Compares one result item with the oldest prediction.
    function void check_result(ilx_pkg::kind_t k, logic [7:0] d, logic l);
      marker_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b", $time, k, d, l);
        mismatches++;
        return;
      end
      e = due.pop_front();
      checked++;
      if (k < 5) kind_seen[k]++;
      if (k !== e.kind) begin
        $display("%0t: kind mismatch, expected %0d, actual %0d", $time, e.kind, k);
        mismatches++;
      end
      if (d !== e.data) begin
        $display("%0t: byte mismatch, expected %02h, actual %02h", $time, e.data, d);
        mismatches++;
      end
      if (l !== e.last) begin
        $display("%0t: last flag mismatch, expected %0b, actual %0b", $time, e.last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] text_byte
  logic       s_axis_tlast;   // end_of_text
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic [2:0] m_axis_tuser;   // [2:0] kind
  logic       m_axis_tlast;   // run_last

  marker_scoreboard sb;
  bit               idle_enable;
  logic [7:0]       text_q[$];
  int unsigned      total_items;
  int unsigned      active_items;
  int unsigned      texts;

  indent_to_block_marker_lexer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin : result_ready
    int unsigned stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idle_enable && $urandom_range(0, 5) == 0)
        stall = $urandom_range(1, 15);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Sends one byte, with an optional gap before it, and waits for acceptance.
  task automatic send_item(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (sb.note_input(b, last)) active_items++;
    total_items++;
    @(negedge clk);
  endtask

  // Sends the buffered text, marking its final byte.
  task automatic send_text();
    if (text_q.size() == 0) text_q.push_back("a");
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts++;
  endtask

  task automatic push_rep(input logic [7:0] b, input int unsigned n);
    repeat (n) text_q.push_back(b);
  endtask

  // Leading whitespace for a level, each unit either a tab or a run of spaces.
  task automatic push_level(input int unsigned lvl);
    repeat (lvl) begin
      if ($urandom_range(0, 1)) text_q.push_back(ilx_pkg::CHAR_TAB);
      else push_rep(ilx_pkg::CHAR_SPACE, ilx_pkg::INDENT_WIDTH);
    end
  endtask

  // A byte that starts a line body.
  function automatic logic [7:0] first_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ilx_pkg::CHAR_SPACE || b == ilx_pkg::CHAR_TAB ||
           b == ilx_pkg::CHAR_NEWLINE);
    return b;
  endfunction

  // A byte inside a line body.
  function automatic logic [7:0] body_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ilx_pkg::CHAR_NEWLINE);
    return b;
  endfunction

  // Builds a random text of a few lines, mostly well indented.
  task automatic build_text();
    int unsigned lines;
    int unsigned r;
    int          lvl;
    lines = $urandom_range(1, 6);
    lvl   = 0;
    repeat (lines) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 9) == 0) lvl = $urandom_range(0, ilx_pkg::MAX_LEVELS);
        else lvl = lvl + $urandom_range(0, 4) - 2;
        if (lvl < 0) lvl = 0;
        if (lvl > ilx_pkg::MAX_LEVELS) lvl = ilx_pkg::MAX_LEVELS;
        push_level(lvl);
        text_q.push_back(first_char());
        repeat ($urandom_range(0, 5)) text_q.push_back(body_char());
        text_q.push_back(ilx_pkg::CHAR_NEWLINE);
      end else if (r < 80) begin
        // Blank line with a valid width.
        push_level($urandom_range(0, 3));
        text_q.push_back(ilx_pkg::CHAR_NEWLINE);
      end else if (r < 86) begin
        // Width that is not a whole number of levels.
        push_level($urandom_range(0, 2));
        push_rep(ilx_pkg::CHAR_SPACE, $urandom_range(1, ilx_pkg::INDENT_WIDTH - 1));
        text_q.push_back($urandom_range(0, 1) ? first_char() : ilx_pkg::CHAR_NEWLINE);
      end else if (r < 92) begin
        // One to three levels beyond the deepest allowed.
        push_rep(ilx_pkg::CHAR_TAB, ilx_pkg::MAX_LEVELS + $urandom_range(1, 3));
        text_q.push_back(first_char());
      end else if (r < 94) begin
        // Enough tabs to saturate the column count.
        push_rep(ilx_pkg::CHAR_TAB, $urandom_range(64, 70));
        text_q.push_back($urandom_range(0, 1) ? first_char() : ilx_pkg::CHAR_NEWLINE);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0:       text_q.push_back(ilx_pkg::CHAR_SPACE);
            1:       text_q.push_back(ilx_pkg::CHAR_TAB);
            2:       text_q.push_back(ilx_pkg::CHAR_NEWLINE);
            default: text_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    // Sometimes end the text with trailing whitespace or drop its last byte.
    r = $urandom_range(0, 99);
    if (r < 30) begin
      repeat ($urandom_range(1, 3))
        text_q.push_back($urandom_range(0, 1) ? ilx_pkg::CHAR_SPACE : ilx_pkg::CHAR_TAB);
    end else if (r < 50 && text_q.size() > 1) begin
      void'(text_q.pop_back());
    end
  endtask

  initial begin
    sb            = new();
    total_items   = 0;
    active_items  = 0;
    texts         = 0;
    idle_enable   = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Indent by two, a blank line, dedent by two onto a zero byte, carriage
    // return, then a bad width blank line and bytes ignored after it.
    text_q.push_back("a");
    text_q.push_back(ilx_pkg::CHAR_NEWLINE);
    push_rep(ilx_pkg::CHAR_TAB, 2);
    text_q.push_back("b");
    text_q.push_back(ilx_pkg::CHAR_NEWLINE);
    push_rep(ilx_pkg::CHAR_SPACE, ilx_pkg::INDENT_WIDTH);
    text_q.push_back(ilx_pkg::CHAR_NEWLINE);
    text_q.push_back(8'h00);
    text_q.push_back(8'h0D);
    text_q.push_back(ilx_pkg::CHAR_NEWLINE);
    text_q.push_back(ilx_pkg::CHAR_SPACE);
    text_q.push_back(ilx_pkg::CHAR_NEWLINE);
    text_q.push_back("z");
    text_q.push_back(8'hFF);
    send_text();

    // Bad width at a line body; the newline ending the text is ignored.
    text_q.push_back(ilx_pkg::CHAR_SPACE);
    text_q.push_back("q");
    text_q.push_back(ilx_pkg::CHAR_NEWLINE);
    send_text();

    // A single all-ones byte, then trailing whitespace alone.
    text_q.push_back(8'hFF);
    send_text();
    text_q.push_back(ilx_pkg::CHAR_TAB);
    send_text();

    // One level deeper than allowed.
    push_rep(ilx_pkg::CHAR_TAB, ilx_pkg::MAX_LEVELS + 1);
    text_q.push_back("x");
    send_text();

    // Random texts; idling stops for the last stretch.
    while (total_items < 270) begin
      idle_enable = (total_items < 230) && ($urandom_range(0, 3) != 0);
      build_text();
      send_text();
    end
    s_axis_tvalid = 1'b0;
    idle_enable   = 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d texts, %0d bytes (%0d before any error), %0d results checked.",
             texts, total_items, active_items, sb.checked);
    $display("Results: byte %0d, indent %0d, dedent %0d, bad width %0d, too deep %0d.",
             sb.kind_seen[ilx_pkg::KIND_BYTE], sb.kind_seen[ilx_pkg::KIND_INDENT],
             sb.kind_seen[ilx_pkg::KIND_DEDENT],
             sb.kind_seen[ilx_pkg::KIND_BAD_WIDTH],
             sb.kind_seen[ilx_pkg::KIND_TOO_DEEP]);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still due.", sb.due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== indent_to_block_marker_lexer.f =====
hw/rtl/ilx_pkg.sv
hw/rtl/ilx_divider.sv
hw/rtl/indent_to_block_marker_lexer.sv
verif/indent_to_block_marker_lexer_tb.sv
